@@ src/bis_pkg.sv @@
// Shared types and constants of the bilinear image scaler.
package bis_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 11;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_HAS_MASK   = 3'd4,
		REG_HAS_ALPHA  = 3'd5
	} reg_idx_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;      // write the input word into the store
		logic capture;   // latch sample coordinates, start dividers
		logic rd_row0;   // issue reads of the upper row
		logic rd_row1;   // issue reads of the lower row
		logic interp;    // run the interpolation from the read words
		logic emit;      // present the result
	} bis_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
	} bis_sts_t;

endpackage

@@ src/bis_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bis_div #(
	parameter int NumW = 38,
	parameter int DenW = 13
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic [NumW-1:0] quot,
	output logic            done
);
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] quot_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            run_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   diff;

	assign trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CntW'(NumW);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1))
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			if (!diff[DenW]) begin
				rem_q <= diff;
				quot_q <= {quot_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign done = !run_q && !start;
endmodule

@@ src/bis_datapath.sv @@
// Datapath: source store, coordinate mapping and bilinear interpolation.
module bis_datapath #(
	parameter int MAX_SRC_WIDTH = 64,
	parameter int MAX_SRC_HEIGHT = 64,
	parameter int MAX_DST_DIM = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bis_pkg::bis_cmd_t cmd,
	output bis_pkg::bis_sts_t sts,
	input  logic [5:0]        src_x,
	input  logic [5:0]        src_y,
	input  logic [23:0]       pixel_rgb,
	input  logic              pixel_opaque,
	input  logic [7:0]        pixel_alpha,
	input  logic [9:0]        dst_x,
	input  logic [9:0]        dst_y,
	input  logic [6:0]        src_width,
	input  logic [6:0]        src_height,
	input  logic [10:0]       dst_width,
	input  logic [10:0]       dst_height,
	input  logic              has_mask,
	input  logic              has_alpha,
	output logic [23:0]       out_rgb,
	output logic              out_opaque,
	output logic [7:0]        out_alpha
);
	import bis_pkg::*;

	localparam int XW = $clog2(MAX_SRC_WIDTH);
	localparam int YW = $clog2(MAX_SRC_HEIGHT);
	localparam int SXW = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SYW = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int DW = $clog2(MAX_DST_DIM + 1);
	localparam int SW = (SXW > SYW) ? SXW : SYW;
	localparam int NumW = 10 + SW + FRAC_BITS;
	localparam int AW = XW + YW;
	localparam int Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int F = FRAC_BITS;
	localparam int UW = 8 + F + 2;   // signed row blend
	localparam int VW = 8 + 2 * F + 3;

	// clamped sizes
	logic [SXW-1:0] sw;
	logic [SYW-1:0] sh;
	logic [DW-1:0]  dw, dh;

	always_comb begin
		sw = (src_width == 7'd0) ? SXW'(1) :
			(32'(src_width) > MAX_SRC_WIDTH) ? SXW'(MAX_SRC_WIDTH) : SXW'(src_width);
		sh = (src_height == 7'd0) ? SYW'(1) :
			(32'(src_height) > MAX_SRC_HEIGHT) ? SYW'(MAX_SRC_HEIGHT) : SYW'(src_height);
		dw = (dst_width == 11'd0) ? DW'(1) :
			(32'(dst_width) > MAX_DST_DIM) ? DW'(MAX_DST_DIM) : DW'(dst_width);
		dh = (dst_height == 11'd0) ? DW'(1) :
			(32'(dst_height) > MAX_DST_DIM) ? DW'(MAX_DST_DIM) : DW'(dst_height);
	end

	// numerators d*src*2^F, products registered before the dividers
	logic [NumW-1:0] numx_q, numy_q;
	logic            go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			go_q <= 1'b0;
		else
			go_q <= cmd.capture;
	end
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			numx_q <= NumW'((NumW'(dst_x) * NumW'(sw)) << F);
			numy_q <= NumW'((NumW'(dst_y) * NumW'(sh)) << F);
		end
	end

	logic [NumW-1:0] qx, qy;
	logic            dx_done, dy_done;
	bis_div #(.NumW(NumW), .DenW(DW)) u_divx (
		.clk(clk), .arst_n(arst_n), .start(go_q), .num(numx_q), .den(dw),
		.quot(qx), .done(dx_done));
	bis_div #(.NumW(NumW), .DenW(DW)) u_divy (
		.clk(clk), .arst_n(arst_n), .start(go_q), .num(numy_q), .den(dh),
		.quot(qy), .done(dy_done));
	assign sts.div_done = dx_done && dy_done && !go_q && !cmd.capture;

	// edge rules
	logic [NumW-F-1:0] ixw, iyw;
	logic [XW-1:0]     ix, ixi;
	logic [YW-1:0]     iy, iyi;
	logic [F-1:0]      fx, fy;
	always_comb begin
		ixw = qx[NumW-1:F];
		iyw = qy[NumW-1:F];
		fx = qx[F-1:0];
		fy = qy[F-1:0];
		if (ixw >= (NumW-F)'(sw)) begin
			ixw = (NumW-F)'(sw) - 1'b1;
			fx = '0;
		end
		if (ixw + 2'd2 >= (NumW-F)'(sw))
			fx = '0;
		if (iyw >= (NumW-F)'(sh)) begin
			iyw = (NumW-F)'(sh) - 1'b1;
			fy = '0;
		end
		if (iyw + 2'd2 >= (NumW-F)'(sh))
			fy = '0;
		ix = ixw[XW-1:0];
		iy = iyw[YW-1:0];
		ixi = (fx != '0) ? ix + 1'b1 : ix;
		iyi = (fy != '0) ? iy + 1'b1 : iy;
	end

	// two banks hold the same words so that two corners read per cycle
	logic [32:0] mem_a [Depth];
	logic [32:0] mem_b [Depth];
	logic [32:0] rd_a, rd_b;
	logic [AW-1:0] ra, rb;
	always_comb begin
		if (cmd.rd_row1) begin
			ra = {iyi, ix};
			rb = {iyi, ixi};
		end else begin
			ra = {iy, ix};
			rb = {iy, ixi};
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_a[{YW'(src_y), XW'(src_x)}] <= {pixel_alpha, pixel_opaque, pixel_rgb};
			mem_b[{YW'(src_y), XW'(src_x)}] <= {pixel_alpha, pixel_opaque, pixel_rgb};
		end
		rd_a <= mem_a[ra];
		rd_b <= mem_b[rb];
	end

	logic        row1_q;
	logic [32:0] c0_q, c1_q;
	logic [F-1:0] fx_q, fy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row1_q <= 1'b0;
		else
			row1_q <= cmd.rd_row0;
	end
	always_ff @(posedge clk) begin
		if (row1_q) begin
			c0_q <= rd_a;
			c1_q <= rd_b;
		end
		if (cmd.rd_row0) begin
			fx_q <= fx;
			fy_q <= fy;
		end
	end

	// row blends for all five channels
	function automatic logic signed [UW-1:0] row_blend(input logic [7:0] l, input logic [7:0] r,
		input logic [F-1:0] f);
		logic signed [9:0]    d;
		logic signed [F:0]    fs;
		logic signed [F+10:0] p;
		begin
			d = $signed({2'b0, r}) - $signed({2'b0, l});
			fs = $signed({1'b0, f});
			p = d * fs;
			row_blend = ($signed({2'b0, l, F'(0)})) + UW'(p);
		end
	endfunction

	function automatic logic [7:0] col_blend(input logic signed [UW-1:0] u,
		input logic signed [UW-1:0] l, input logic [F-1:0] f);
		logic signed [UW-1:0] dl;
		logic signed [F:0]    fs;
		logic signed [UW+F:0] p;
		logic signed [VW-1:0] v;
		begin
			dl = l - u;
			fs = $signed({1'b0, f});
			p = dl * fs;
			v = (VW'(u) <<< F) + VW'(p);
			v = v + (VW'(1) <<< (2 * F - 1));
			col_blend = v[2*F+7:2*F];
		end
	endfunction

	logic signed [UW-1:0] u_s1 [5];
	logic signed [UW-1:0] l_s1 [5];
	logic [32:0] c0_s1, c1_s1, c2_s1, c3_s1;
	logic        blend_q;
	logic [7:0]  ch0 [5], ch1 [5];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ch0[k] = c0_q[8*k +: 8];
			ch1[k] = c1_q[8*k +: 8];
		end
		ch0[3] = {7'd0, c0_q[24]};
		ch1[3] = {7'd0, c1_q[24]};
		ch0[4] = c0_q[32:25];
		ch1[4] = c1_q[32:25];
	end
	logic [7:0] ch2 [5], ch3 [5];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ch2[k] = rd_a[8*k +: 8];
			ch3[k] = rd_b[8*k +: 8];
		end
		ch2[3] = {7'd0, rd_a[24]};
		ch3[3] = {7'd0, rd_b[24]};
		ch2[4] = rd_a[32:25];
		ch3[4] = rd_b[32:25];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			blend_q <= 1'b0;
		else
			blend_q <= cmd.interp;
	end
	always_ff @(posedge clk) begin
		if (cmd.interp) begin
			for (int k = 0; k < 5; k++) begin
				u_s1[k] <= row_blend(ch0[k], ch1[k], fx_q);
				l_s1[k] <= row_blend(ch2[k], ch3[k], fx_q);
			end
			c0_s1 <= c0_q;
			c1_s1 <= c1_q;
			c2_s1 <= rd_a;
			c3_s1 <= rd_b;
		end
	end

	logic [7:0] res [5];
	always_comb begin
		for (int k = 0; k < 5; k++)
			res[k] = col_blend(u_s1[k], l_s1[k], fy_q);
	end

	logic [23:0] rgb_q;
	logic        opq_q;
	logic [7:0]  alpha_q;
	logic [23:0] rgb_n;
	always_comb begin
		if (c0_s1[23:0] == c1_s1[23:0] && c0_s1[23:0] == c2_s1[23:0] &&
			c0_s1[23:0] == c3_s1[23:0])
			rgb_n = c0_s1[23:0];
		else
			rgb_n = {res[2], res[1], res[0]};
	end
	always_ff @(posedge clk) begin
		if (blend_q) begin
			if (has_mask && res[3] == 8'd0) begin
				rgb_q <= '0;
				opq_q <= 1'b0;
				alpha_q <= '0;
			end else begin
				rgb_q <= rgb_n;
				opq_q <= 1'b1;
				alpha_q <= has_alpha ? res[4] : 8'hff;
			end
		end
	end

	assign out_rgb = rgb_q;
	assign out_opaque = opq_q;
	assign out_alpha = alpha_q;
endmodule

@@ src/bis_ctrl.sv @@
// Controller state machine sequencing loads and samples.
module bis_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op,
	input  bis_pkg::bis_sts_t sts,
	output bis_pkg::bis_cmd_t cmd,
	output logic              busy,
	output logic              done
);
	import bis_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV   = 7'b0000010,
		S_ROW0  = 7'b0000100,
		S_ROW1  = 7'b0001000,
		S_INTP  = 7'b0010000,
		S_COL   = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q, state_n;
	logic   accept;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: if (accept && op == OP_SAMPLE) state_n = S_DIV;
			S_DIV:  if (sts.div_done) state_n = S_ROW0;
			S_ROW0: state_n = S_ROW1;
			S_ROW1: state_n = S_INTP;
			S_INTP: state_n = S_COL;
			S_COL:  state_n = S_EMIT;
			S_EMIT: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		cmd = '0;
		cmd.load = accept && op == OP_LOAD;
		cmd.capture = accept && op == OP_SAMPLE;
		cmd.rd_row0 = (state_q == S_ROW0);
		cmd.rd_row1 = (state_q == S_ROW1);
		cmd.interp = (state_q == S_INTP);
		cmd.emit = (state_q == S_EMIT);
	end

	assign done = cmd.emit;
endmodule

@@ src/bilinear_image_scaler.sv @@
// Top level of the bilinear image scaler.
//  channel   signals                                  direction
//  command   start, busy, op, src_*, pixel_*, dst_*   in (busy out)
//  result    done, out_rgb, out_opaque, out_alpha     out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
// A load writes the store at its accept edge. A sample raises done once the steps
// below are through, and the next word is taken in the cycle after done:
// the bit-serial coordinate dividers run FRAC_BITS+17 quotient bits, then come
// two store reads and two blend steps.
// Reset clears control and presets the config registers; datapath registers and the store are undefined until written.
// Results come with done for one cycle; the receiver cannot stall.
module bilinear_image_scaler #(
	parameter int MAX_SRC_WIDTH = 64,
	parameter int MAX_SRC_HEIGHT = 64,
	parameter int MAX_DST_DIM = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [5:0]                     src_x,
	input  logic [5:0]                     src_y,
	input  logic [23:0]                    pixel_rgb,
	input  logic                           pixel_opaque,
	input  logic [7:0]                     pixel_alpha,
	input  logic [9:0]                     dst_x,
	input  logic [9:0]                     dst_y,
	output logic                           done,
	output logic [23:0]                    out_rgb,
	output logic                           out_opaque,
	output logic [7:0]                     out_alpha,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bis_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [bis_pkg::CfgDataW-1:0]   cfg_data
);
	import bis_pkg::*;

	logic [6:0]  src_width_q, src_height_q;
	logic [10:0] dst_width_q, dst_height_q;
	logic        has_mask_q, has_alpha_q;
	bis_cmd_t    cmd;
	bis_sts_t    sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= 7'd64;
			src_height_q <= 7'd64;
			dst_width_q <= 11'd64;
			dst_height_q <= 11'd64;
			has_mask_q <= 1'b0;
			has_alpha_q <= 1'b0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q <= cfg_data[6:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[6:0];
				REG_DST_WIDTH:  dst_width_q <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				REG_HAS_MASK:   has_mask_q <= cfg_data[0];
				REG_HAS_ALPHA:  has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done));

	bis_datapath #(
		.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
		.MAX_DST_DIM(MAX_DST_DIM), .FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.src_x(src_x), .src_y(src_y), .pixel_rgb(pixel_rgb),
		.pixel_opaque(pixel_opaque), .pixel_alpha(pixel_alpha),
		.dst_x(dst_x), .dst_y(dst_y),
		.src_width(src_width_q), .src_height(src_height_q),
		.dst_width(dst_width_q), .dst_height(dst_height_q),
		.has_mask(has_mask_q), .has_alpha(has_alpha_q),
		.out_rgb(out_rgb), .out_opaque(out_opaque), .out_alpha(out_alpha));
endmodule
